@@ design/oaids_pkg.sv @@
// ----------------------------------------------------------------------------
// oaids_pkg
// Shared types and constants for the ordered list store: request kinds,
// result status codes, cell commands and stream word widths.
// ----------------------------------------------------------------------------
package oaids_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned S_TDATA_W = 40;  // position + operand, padded to bytes
  localparam int unsigned M_TDATA_W = 80;  // removed + found + total + count, padded

  // Position reported by a search that finds nothing, or by any other request.
  localparam logic [POS_W-1:0] FOUND_NONE = '1;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Command broadcast to every cell of the chain in the same cycle.
  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_LOAD   = 3'd1,  // copy the entry into the probe line
    CELL_SHIFT  = 3'd2,  // probe line moves one cell towards cell 0
    CELL_INSERT = 3'd3,
    CELL_DELETE = 3'd4
  } cell_op_e;

endpackage

@@ design/oaids_cell.sv @@
// ----------------------------------------------------------------------------
// oaids_cell
// One position of the list: holds its entry and one word of the probe line,
// and trades data with its neighbours on insert, delete and probe shifts.
// ----------------------------------------------------------------------------
module oaids_cell #(
  parameter int unsigned IW    = 4,
  parameter int unsigned INDEX = 0
) (
  input  logic                           clk_i,
  input  oaids_pkg::cell_op_e            op_i,
  input  logic [IW-1:0]                  pos_i,
  input  logic [oaids_pkg::DATA_W-1:0]   operand_i,
  input  logic [oaids_pkg::DATA_W-1:0]   below_entry_i,
  input  logic [oaids_pkg::DATA_W-1:0]   above_entry_i,
  input  logic [oaids_pkg::DATA_W-1:0]   above_probe_i,
  output logic [oaids_pkg::DATA_W-1:0]   entry_o,
  output logic [oaids_pkg::DATA_W-1:0]   probe_o
);

  localparam logic [IW-1:0] Idx = IW'(INDEX);

  logic [oaids_pkg::DATA_W-1:0] entry_q, entry_d;
  logic [oaids_pkg::DATA_W-1:0] probe_q, probe_d;

  always_comb begin
    entry_d = entry_q;
    probe_d = probe_q;
    unique case (op_i)
      oaids_pkg::CELL_HOLD: begin
      end
      oaids_pkg::CELL_LOAD: begin
        probe_d = entry_q;
      end
      oaids_pkg::CELL_SHIFT: begin
        probe_d = above_probe_i;
      end
      oaids_pkg::CELL_INSERT: begin
        if (Idx > pos_i) begin
          entry_d = below_entry_i;
        end else if (Idx == pos_i) begin
          entry_d = operand_i;
        end
      end
      oaids_pkg::CELL_DELETE: begin
        if (Idx >= pos_i) begin
          entry_d = above_entry_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    probe_q <= probe_d;
  end

  assign entry_o = entry_q;
  assign probe_o = probe_q;

endmodule

@@ design/ordered_array_insert_delete_search.sv @@
// ----------------------------------------------------------------------------
// ordered_array_insert_delete_search
// Insert, rejected requests and unused kinds finish without a walk; delete
// walks the probe line up to its position; search walks it until a match or
// until the count is reached. One request is in work at a time, so a new
// word is only taken once the last one has finished.
// Reset clears the count, the sum and all handshake state; entries are not
// cleared and only positions below the count are ever read.
// ----------------------------------------------------------------------------
// The store is a chain of DEPTH cells. Each cell holds one entry and one word
// of a probe line. Insert and delete move every entry above the target
// position by one cell, all in the same cycle. Every accepted word copies the
// entries into the probe line; for search and delete the probe line then
// moves one cell towards cell 0 per cycle, so the controller only ever
// looks at cell 0: it compares that word with the key, or takes it as the
// removed value once the walk has reached the delete position.
//
// The result sits in an output register, so a finished word can wait for the
// downstream side while the block returns to idle and takes the next request.
module ordered_array_insert_delete_search #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Request side.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata, low bit first: position [4:0], operand [36:5], zero [39:37].
  input  logic [oaids_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // tuser: kind [1:0].
  input  logic [1:0]                        s_axis_tuser,
  // Result side.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata, low bit first: removed_value [31:0], found_at [36:32],
  // total [68:37], count [73:69], zero [79:74].
  output logic [oaids_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // tuser: status [1:0].
  output logic [1:0]                        m_axis_tuser
);

  // Index width for the cells, width of the fill count and a common width
  // wide enough to compare the 5-bit position field with the count.
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned WW = (CW > oaids_pkg::POS_W) ? CW : oaids_pkg::POS_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e                         state_q, state_d;
  oaids_pkg::kind_e               kind_q;
  logic [oaids_pkg::POS_W-1:0]    pos_q;
  logic [oaids_pkg::DATA_W-1:0]   oper_q;
  logic [CW-1:0]                  fill_q, fill_d;
  logic [oaids_pkg::DATA_W-1:0]   sum_q, sum_d;
  logic [CW-1:0]                  step_q;

  logic                           out_valid_q;
  logic [1:0]                     status_q;
  logic [oaids_pkg::DATA_W-1:0]   removed_q;
  logic [oaids_pkg::POS_W-1:0]    found_q;
  logic [oaids_pkg::DATA_W-1:0]   total_q;
  logic [oaids_pkg::COUNT_W-1:0]  count_q;

  logic                           s_accept;
  logic                           slot_free;
  logic                           done;
  logic                           fire;
  logic                           shift;
  oaids_pkg::status_e             status_c;
  logic [oaids_pkg::DATA_W-1:0]   removed_c;
  logic [oaids_pkg::POS_W-1:0]    found_c;
  oaids_pkg::cell_op_e            commit_op;
  oaids_pkg::cell_op_e            cell_op;

  logic [WW-1:0]                  fill_ext;
  logic [WW-1:0]                  pos_ext;
  logic [WW-1:0]                  step_ext;
  logic [WW-1:0]                  fill_next_ext;
  logic [IW-1:0]                  cell_pos;

  logic [oaids_pkg::DATA_W-1:0]   entry_w [DEPTH];
  logic [oaids_pkg::DATA_W-1:0]   probe_w [DEPTH];
  logic [oaids_pkg::DATA_W-1:0]   probe0;

  assign s_accept  = s_axis_tvalid && s_axis_tready;
  assign slot_free = !out_valid_q || m_axis_tready;

  assign fill_ext = WW'(fill_q);
  assign pos_ext  = WW'(pos_q);
  assign step_ext = WW'(step_q);
  // A position that passes the range checks is below DEPTH, so it fits IW bits.
  assign cell_pos = IW'(pos_ext);
  assign probe0   = probe_w[0];

  // Decide, for the request in work, whether it finishes this cycle and how.
  always_comb begin
    done      = 1'b0;
    shift     = 1'b0;
    status_c  = oaids_pkg::STATUS_DONE;
    removed_c = '0;
    found_c   = oaids_pkg::FOUND_NONE;
    commit_op = oaids_pkg::CELL_HOLD;
    fill_d    = fill_q;
    sum_d     = sum_q;
    if (state_q == ST_RUN) begin
      unique case (kind_q)
        oaids_pkg::KIND_INSERT: begin
          done = 1'b1;
          if (pos_ext > fill_ext) begin
            status_c = oaids_pkg::STATUS_RANGE;
          end else if (fill_q == CW'(DEPTH)) begin
            status_c = oaids_pkg::STATUS_FULL;
          end else begin
            commit_op = oaids_pkg::CELL_INSERT;
            fill_d    = fill_q + CW'(1);
            sum_d     = sum_q + oper_q;
          end
        end
        oaids_pkg::KIND_DELETE: begin
          if (pos_ext >= fill_ext) begin
            done     = 1'b1;
            status_c = oaids_pkg::STATUS_RANGE;
          end else if (step_ext == pos_ext) begin
            done      = 1'b1;
            removed_c = probe0;
            commit_op = oaids_pkg::CELL_DELETE;
            fill_d    = fill_q - CW'(1);
            sum_d     = sum_q - probe0;
          end else begin
            shift = 1'b1;
          end
        end
        oaids_pkg::KIND_SEARCH: begin
          if (step_q == fill_q) begin
            done = 1'b1;
          end else if (probe0 == oper_q) begin
            done    = 1'b1;
            found_c = step_ext[oaids_pkg::POS_W-1:0];
          end else begin
            shift = 1'b1;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
  end

  // The entries only change once the result can be written out.
  assign fire = done && slot_free;

  always_comb begin
    cell_op = oaids_pkg::CELL_HOLD;
    if (s_accept) begin
      cell_op = oaids_pkg::CELL_LOAD;
    end else if (fire) begin
      cell_op = commit_op;
    end else if (shift) begin
      cell_op = oaids_pkg::CELL_SHIFT;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      sum_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        fill_q <= fill_d;
        sum_q  <= sum_d;
      end
      if (s_accept) begin
        step_q <= '0;
      end else if (shift) begin
        step_q <= step_q + CW'(1);
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      kind_q <= oaids_pkg::kind_e'(s_axis_tuser);
      pos_q  <= s_axis_tdata[oaids_pkg::POS_W-1:0];
      oper_q <= s_axis_tdata[oaids_pkg::POS_W +: oaids_pkg::DATA_W];
    end
    if (fire) begin
      status_q  <= status_c;
      removed_q <= removed_c;
      found_q   <= found_c;
      total_q   <= sum_d;
      count_q   <= fill_next_ext[oaids_pkg::COUNT_W-1:0];
    end
  end

  assign fill_next_ext = WW'(fill_d);

  // The chain of cells. The top cell sees itself above and an empty probe;
  // the bottom cell never takes its lower neighbour, so it sees the operand.
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic [oaids_pkg::DATA_W-1:0] below_w;
    logic [oaids_pkg::DATA_W-1:0] above_w;
    logic [oaids_pkg::DATA_W-1:0] above_probe_w;

    if (gi == 0) begin : g_bottom
      assign below_w = oper_q;
    end else begin : g_below
      assign below_w = entry_w[gi-1];
    end

    if (gi == DEPTH - 1) begin : g_top
      assign above_w       = entry_w[gi];
      assign above_probe_w = '0;
    end else begin : g_above
      assign above_w       = entry_w[gi+1];
      assign above_probe_w = probe_w[gi+1];
    end

    oaids_cell #(
      .IW    (IW),
      .INDEX (gi)
    ) u_cell (
      .clk_i         (clk_i),
      .op_i          (cell_op),
      .pos_i         (cell_pos),
      .operand_i     (oper_q),
      .below_entry_i (below_w),
      .above_entry_i (above_w),
      .above_probe_i (above_probe_w),
      .entry_o       (entry_w[gi]),
      .probe_o       (probe_w[gi])
    );
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = oaids_pkg::M_TDATA_W'({count_q, total_q, found_q, removed_q});

endmodule

@@ design/oaids_checker.sv @@
// ----------------------------------------------------------------------------
// oaids_checker
// Port-level checks on the ordered list store, attached to the top level by
// the bind statement at the end of this file.
// ----------------------------------------------------------------------------
module oaids_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [oaids_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  input logic [1:0]                        m_axis_tuser
);

  localparam logic [oaids_pkg::COUNT_W-1:0] DepthLow = oaids_pkg::COUNT_W'(DEPTH);
  localparam bit Narrow = (DEPTH < 32);

  logic [oaids_pkg::POS_W-1:0]   found_w;
  logic [oaids_pkg::COUNT_W-1:0] count_w;

  assign found_w = m_axis_tdata[36:32];
  assign count_w = m_axis_tdata[73:69];

  // Only one request is in work at a time: a taken word closes the input.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while another is in work");

  // A result word waiting downstream is not withdrawn.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // The count never goes beyond the capacity of the store.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!Narrow || count_w <= DepthLow))
    else $error("count exceeds capacity");

  // A full rejection is only reported when the store really is full.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == oaids_pkg::STATUS_FULL |-> count_w == DepthLow)
    else $error("store full reported below capacity");

  // A reported match lies inside the held entries of a completed request.
  a_found_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && found_w != oaids_pkg::FOUND_NONE |->
      m_axis_tuser == oaids_pkg::STATUS_DONE && (!Narrow || found_w < count_w))
    else $error("match position outside held entries");

endmodule

bind ordered_array_insert_delete_search oaids_checker #(.DEPTH(DEPTH)) u_oaids_checker (.*);

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ordered list store. A short table of directed
// requests exercises empty and full stores, both ends of the operand range and
// every request kind. About a thousand random requests follow, grouped into
// growing and shrinking phases so that the store often fills and empties.
// Each result word is checked field by field against a typed answer or a
// behavioural copy of the store that the bench keeps for itself.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned LIST_DEPTH   = 16;
  localparam int unsigned RANDOM_ITEMS = 1100;
  // The final stretch of the random part runs with both sides always ready.
  localparam int unsigned CALM_ITEMS   = 150;
  // Settling time after the final drain, long enough for any straggler.
  localparam int unsigned END_SETTLE   = 40;

  // One result word, split into its fields.
  typedef struct packed {
    oaids_pkg::status_e status;
    logic signed [31:0] removed;
    logic signed [4:0]  found_at;
    logic signed [31:0] total;
    logic [4:0]         count;
  } reply_t;

  // One row of the directed table. A row with a typed answer carries it in
  // want; every other row is checked against the bench's own copy of the store.
  typedef struct {
    oaids_pkg::kind_e kind;
    logic [4:0]       position;
    logic [31:0]      operand;
    int unsigned      reps;
    bit               typed;
    reply_t           want;
  } request_row_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // The bench's copy of the store, kept in step with every request word sent.
  logic [31:0] shadow_entries [LIST_DEPTH];
  int unsigned shadow_fill = 0;
  logic [31:0] shadow_sum  = '0;

  // Results still owed by the block, oldest first.
  reply_t       replies_due [$];
  request_row_t directed_rows [$];
  int unsigned  error_count = 0;
  // Set for the last part of the run: no idling on either side.
  bit           calm = 1'b0;

  ordered_array_insert_delete_search #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Applies one request to the bench's copy of the store and returns the
  // result word that the block ought to give for it.
  function automatic reply_t apply_request(oaids_pkg::kind_e kind, logic [4:0] pos,
                                           logic [31:0] operand);
    reply_t r;
    int     i;
    r.status   = oaids_pkg::STATUS_DONE;
    r.removed  = '0;
    r.found_at = oaids_pkg::FOUND_NONE;
    case (kind)
      oaids_pkg::KIND_INSERT: begin
        // The position check takes precedence over the full check.
        if (pos > shadow_fill) begin
          r.status = oaids_pkg::STATUS_RANGE;
        end else if (shadow_fill >= LIST_DEPTH) begin
          r.status = oaids_pkg::STATUS_FULL;
        end else begin
          for (i = shadow_fill; i > pos; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[pos] = operand;
          shadow_fill++;
          shadow_sum += operand;
        end
      end
      oaids_pkg::KIND_DELETE: begin
        if (pos >= shadow_fill) begin
          r.status = oaids_pkg::STATUS_RANGE;
        end else begin
          r.removed = shadow_entries[pos];
          for (i = pos; i + 1 < shadow_fill; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_fill--;
          shadow_sum -= r.removed;
        end
      end
      oaids_pkg::KIND_SEARCH: begin
        // The lowest matching position wins; the position field plays no part.
        for (i = 0; i < shadow_fill && r.found_at == oaids_pkg::FOUND_NONE; i++) begin
          if (shadow_entries[i] == operand) r.found_at = i[4:0];
        end
      end
      default: ;
    endcase
    r.total = shadow_sum;
    r.count = shadow_fill[4:0];
    return r;
  endfunction

  // Operand values: mostly uniform, with a share of extremes and of a few small
  // values so that duplicates turn up and searches hit more than one match.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return 32'($urandom_range(0, 4)) - 32'd2;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(oaids_pkg::kind_e kind, logic [4:0] pos, logic [31:0] operand,
                         int unsigned reps);
    request_row_t row;
    row.kind     = kind;
    row.position = pos;
    row.operand  = operand;
    row.reps     = reps;
    row.typed    = 1'b0;
    row.want     = '0;
    directed_rows.push_back(row);
  endtask

  // Rows whose answer is plain from the request alone: nothing removed and
  // no match reported.
  task automatic add_typed(oaids_pkg::kind_e kind, logic [4:0] pos, logic [31:0] operand,
                           oaids_pkg::status_e status, logic [31:0] total,
                           logic [4:0] count);
    request_row_t row;
    row.kind          = kind;
    row.position      = pos;
    row.operand       = operand;
    row.reps          = 1;
    row.typed         = 1'b1;
    row.want.status   = status;
    row.want.removed  = '0;
    row.want.found_at = oaids_pkg::FOUND_NONE;
    row.want.total    = total;
    row.want.count    = count;
    directed_rows.push_back(row);
  endtask

  // Presents one request word and holds it until the block takes it. The
  // expectation is queued at once: a result cannot come before acceptance.
  task automatic send_request(oaids_pkg::kind_e kind, logic [4:0] pos,
                              logic [31:0] operand, bit typed, reply_t want);
    reply_t predicted;
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    predicted = apply_request(kind, pos, operand);
    replies_due.push_back(typed ? want : predicted);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, operand, pos};
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Lowers valid and waits until every owed result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      error_count++;
    end
  endtask

  // Result side: random stalls between ready stretches of varying length, and
  // ready held high once the run turns calm.
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // Result checker: every accepted word is matched with the oldest expectation.
  always @(posedge clk_i) begin
    reply_t got;
    reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status   = oaids_pkg::status_e'(m_axis_tuser);
      got.removed  = m_axis_tdata[31:0];
      got.found_at = m_axis_tdata[36:32];
      got.total    = m_axis_tdata[68:37];
      got.count    = m_axis_tdata[73:69];
      if (replies_due.size() == 0) begin
        $display("%0t: result word with none expected, status %0d, total %0h, count %0d",
                 $time, got.status, got.total, got.count);
        error_count++;
      end else begin
        want = replies_due.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("removed_value", want.removed, got.removed);
        compare_field("found_at", want.found_at, got.found_at);
        compare_field("total", want.total, got.total);
        compare_field("count", want.count, got.count);
      end
    end
  end

  // Main sequence: reset, directed table, random phases, then the wrap-up.
  initial begin
    request_row_t     row;
    oaids_pkg::kind_e kind;
    logic [4:0]       pos;
    logic [31:0]      operand;
    int unsigned      roll;
    int unsigned      top;
    bit               growing;

    // Empty store: every kind answers with zero total and count.
    add_typed(oaids_pkg::KIND_SEARCH, 5'd0,  32'h0000_0000, oaids_pkg::STATUS_DONE,
              32'h0, 5'd0);
    add_typed(oaids_pkg::KIND_DELETE, 5'd0,  32'h0000_0000, oaids_pkg::STATUS_RANGE,
              32'h0, 5'd0);
    add_typed(oaids_pkg::KIND_INSERT, 5'd1,  32'h0000_0005, oaids_pkg::STATUS_RANGE,
              32'h0, 5'd0);
    add_typed(oaids_pkg::KIND_NONE,   5'd31, 32'hFFFF_FFFF, oaids_pkg::STATUS_DONE,
              32'h0, 5'd0);
    // Both extremes of the operand; their sum is all ones.
    add_typed(oaids_pkg::KIND_INSERT, 5'd0,  32'h7FFF_FFFF, oaids_pkg::STATUS_DONE,
              32'h7FFF_FFFF, 5'd1);
    add_typed(oaids_pkg::KIND_INSERT, 5'd0,  32'h8000_0000, oaids_pkg::STATUS_DONE,
              32'hFFFF_FFFF, 5'd2);
    // Append at the end, then fill to the brim with one repeated value.
    add_row(oaids_pkg::KIND_INSERT, 5'd2,  32'hFFFF_FFFF, 1);
    add_row(oaids_pkg::KIND_INSERT, 5'd1,  32'h0000_002A, 13);
    // Full store: a position in range is refused as full, one beyond the append
    // position is refused as out of range since that check comes first.
    add_row(oaids_pkg::KIND_INSERT, 5'd0,  32'h1234_5678, 1);
    add_row(oaids_pkg::KIND_INSERT, 5'd17, 32'h1234_5678, 1);
    // Searches: first of many duplicates (position ignored), last cell, miss.
    add_row(oaids_pkg::KIND_SEARCH, 5'd31, 32'h0000_002A, 1);
    add_row(oaids_pkg::KIND_SEARCH, 5'd0,  32'hFFFF_FFFF, 1);
    add_row(oaids_pkg::KIND_SEARCH, 5'd0,  32'h1234_5678, 1);
    // Deletes: top cell, a middle cell, and past the end.
    add_row(oaids_pkg::KIND_DELETE, 5'd15, 32'h0000_0000, 1);
    add_row(oaids_pkg::KIND_DELETE, 5'd7,  32'h0000_0000, 1);
    add_row(oaids_pkg::KIND_DELETE, 5'd31, 32'h0000_0000, 1);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      repeat (row.reps) send_request(row.kind, row.position, row.operand, row.typed,
                                     row.want);
    end
    drain_results();

    // Random part. Phases of 120 words alternate between favouring inserts
    // and favouring deletes, so the store keeps swinging between empty and
    // full. Positions are mostly legal, with the boundary and the whole
    // field range mixed in; search keys are mostly taken from the store.
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain_results();
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      growing = ((n / 120) % 2) == 0;
      roll = $urandom_range(0, 99);
      if (roll < 5) kind = oaids_pkg::KIND_NONE;
      else if (roll < 25) kind = oaids_pkg::KIND_SEARCH;
      else if (roll < (growing ? 80 : 50)) kind = oaids_pkg::KIND_INSERT;
      else kind = oaids_pkg::KIND_DELETE;

      top = (kind == oaids_pkg::KIND_DELETE && shadow_fill > 0) ? shadow_fill - 1
                                                                : shadow_fill;
      case ($urandom_range(0, 9))
        0:       pos = 5'($urandom_range(0, 31));
        1:       pos = shadow_fill[4:0];
        default: pos = 5'($urandom_range(0, top));
      endcase

      if (kind == oaids_pkg::KIND_SEARCH && shadow_fill > 0 && $urandom_range(0, 9) < 6)
        operand = shadow_entries[$urandom_range(0, shadow_fill - 1)];
      else
        operand = pick_word();

      send_request(kind, pos, operand, 1'b0, '0);
    end

    drain_results();
    repeat (END_SETTLE) @(posedge clk_i);
    if (error_count == 0 && replies_due.size() == 0) begin
      $display("** ordered_array_insert_delete_search: PASSED **");
    end else begin
      $display("** ordered_array_insert_delete_search: FAILED **");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a millisecond.
  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, replies_due.size());
    $display("** ordered_array_insert_delete_search: FAILED **");
    $finish;
  end

endmodule
